// ----- src/tcpc_pkg.sv -----
// Shared types and constants for the trickle-charge PWM controller.
// No dependencies; used by tcpc_step and trickle_charge_pwm_controller.
package tcpc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RegW    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TRICKLE_START = 3'd0,
    REG_PACK_MAX      = 3'd1,
    REG_EXIT_HYST     = 3'd2,
    REG_PULSE_ON      = 3'd3,
    REG_PULSE_OFF     = 3'd4,
    REG_TRICKLE_CUR   = 3'd5,
    REG_FULL_CUR      = 3'd6
  } cfg_idx_t;

  localparam logic [RegW-1:0] RstTrickleStart = 16'd5800;
  localparam logic [RegW-1:0] RstPackMax      = 16'd6000;
  localparam logic [RegW-1:0] RstExitHyst     = 16'd300;
  localparam logic [RegW-1:0] RstPulseOn      = 16'd1000;
  localparam logic [RegW-1:0] RstPulseOff     = 16'd1000;
  localparam logic [RegW-1:0] RstTrickleCur   = 16'd20;
  localparam logic [RegW-1:0] RstFullCur      = 16'd100;

  typedef struct packed {
    logic [15:0] trickle_start_voltage_dv;
    logic [15:0] pack_max_voltage_dv;
    logic [15:0] exit_hysteresis_dv;
    logic [15:0] pulse_on_ms;
    logic [15:0] pulse_off_ms;
    logic [15:0] trickle_current_da;
    logic [15:0] full_current_da;
  } cfg_t;

  typedef struct packed {
    logic        charging_mode;
    logic [31:0] now_ms;
    logic [15:0] pack_voltage_dv;
  } item_t;

  typedef struct packed {
    logic        trickle_enabled;
    logic        pulse_on_phase;
    logic [31:0] last_toggle_time;
  } state_t;

  typedef struct packed {
    logic        limits_valid;
    logic [15:0] voltage_limit_dv;
    logic [15:0] current_limit_da;
    logic        start_control;
    logic        charging_active;
    logic        trickle_active;
  } result_t;

endpackage

// ----- src/tcpc_step.sv -----
// One control tick: trickle mode entry/exit, pulse phase timing and limits.
// Depends on tcpc_pkg; purely combinational.
module tcpc_step (
  input  tcpc_pkg::cfg_t    cfg,
  input  tcpc_pkg::state_t  state,
  input  tcpc_pkg::item_t   item,
  output tcpc_pkg::state_t  state_nxt,
  output tcpc_pkg::result_t res
);
  import tcpc_pkg::*;

  logic        enter;
  logic        leave;
  logic        trickle;
  logic        phase;
  logic [31:0] last;
  logic [31:0] elapsed;
  logic [16:0] exit_sum;
  logic        phase_nxt;
  logic        toggle;

  always_comb begin
    exit_sum = {1'b0, item.pack_voltage_dv} + {1'b0, cfg.exit_hysteresis_dv};
    enter    = !state.trickle_enabled && (item.pack_voltage_dv >= cfg.trickle_start_voltage_dv);
    leave    = state.trickle_enabled && (exit_sum <= {1'b0, cfg.pack_max_voltage_dv});
    trickle  = enter || (state.trickle_enabled && !leave);
    phase    = (enter || leave) ? 1'b1 : state.pulse_on_phase;
    last     = enter ? item.now_ms : state.last_toggle_time;
    elapsed  = item.now_ms - last;
    // compare elapsed against the length of the current phase
    if (phase) begin
      toggle = elapsed >= {16'd0, cfg.pulse_on_ms};
    end else begin
      toggle = elapsed >= {16'd0, cfg.pulse_off_ms};
    end
    phase_nxt = (trickle && toggle) ? !phase : phase;

    if (!item.charging_mode) begin
      state_nxt.trickle_enabled  = 1'b0;
      state_nxt.pulse_on_phase   = 1'b1;
      state_nxt.last_toggle_time = state.last_toggle_time;
      res.limits_valid           = 1'b0;
      res.voltage_limit_dv       = '0;
      res.current_limit_da       = '0;
      res.start_control          = 1'b1;
      res.charging_active        = 1'b0;
      res.trickle_active         = 1'b0;
    end else begin
      state_nxt.trickle_enabled  = trickle;
      state_nxt.pulse_on_phase   = phase_nxt;
      state_nxt.last_toggle_time = (trickle && toggle) ? item.now_ms : last;
      res.limits_valid           = 1'b1;
      res.voltage_limit_dv       = cfg.pack_max_voltage_dv;
      res.start_control          = 1'b0;
      res.trickle_active         = trickle;
      if (!trickle) begin
        res.current_limit_da = cfg.full_current_da;
        res.charging_active  = 1'b1;
      end else if (phase_nxt) begin
        res.current_limit_da = cfg.trickle_current_da;
        res.charging_active  = 1'b1;
      end else begin
        res.current_limit_da = '0;
        res.charging_active  = 1'b0;
      end
    end
  end

endmodule

// ----- src/trickle_charge_pwm_controller.sv -----
// Trickle-charge PWM controller top level: config registers, input and result stages.
// Throughput: one item per cycle while the output is not held back by out_ready.
// The tick logic sits between the input register and the result register; controller
// state updates as an item moves into the result register.
// Reset (synchronous, rst_n low): both stages empty, registers to defaults,
// trickle off, on phase preset, toggle time zero.
module trickle_charge_pwm_controller (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_charging_mode,
  input  logic [31:0]              in_now_ms,
  input  logic [15:0]              in_pack_voltage_dv,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_limits_valid,
  output logic [15:0]              out_voltage_limit_dv,
  output logic [15:0]              out_current_limit_da,
  output logic                     out_start_control,
  output logic                     out_charging_active,
  output logic                     out_trickle_active
);
  import tcpc_pkg::*;

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  item_t   item_r;
  result_t res_r;
  result_t res_nxt;
  logic    in_valid_r;
  logic    out_valid_r;
  logic    advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  tcpc_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trickle_start_voltage_dv <= RstTrickleStart;
      cfg_r.pack_max_voltage_dv      <= RstPackMax;
      cfg_r.exit_hysteresis_dv       <= RstExitHyst;
      cfg_r.pulse_on_ms              <= RstPulseOn;
      cfg_r.pulse_off_ms             <= RstPulseOff;
      cfg_r.trickle_current_da       <= RstTrickleCur;
      cfg_r.full_current_da          <= RstFullCur;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRICKLE_START: cfg_r.trickle_start_voltage_dv <= cfg_wdata;
        REG_PACK_MAX:      cfg_r.pack_max_voltage_dv      <= cfg_wdata;
        REG_EXIT_HYST:     cfg_r.exit_hysteresis_dv       <= cfg_wdata;
        REG_PULSE_ON:      cfg_r.pulse_on_ms              <= cfg_wdata;
        REG_PULSE_OFF:     cfg_r.pulse_off_ms             <= cfg_wdata;
        REG_TRICKLE_CUR:   cfg_r.trickle_current_da       <= cfg_wdata;
        REG_FULL_CUR:      cfg_r.full_current_da          <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r.trickle_enabled  <= 1'b0;
      state_r.pulse_on_phase   <= 1'b1;
      state_r.last_toggle_time <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.charging_mode   <= in_charging_mode;
      item_r.now_ms          <= in_now_ms;
      item_r.pack_voltage_dv <= in_pack_voltage_dv;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_limits_valid     = res_r.limits_valid;
  assign out_voltage_limit_dv = res_r.voltage_limit_dv;
  assign out_current_limit_da = res_r.current_limit_da;
  assign out_start_control    = res_r.start_control;
  assign out_charging_active  = res_r.charging_active;
  assign out_trickle_active   = res_r.trickle_active;

endmodule
